FILE: hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// clocked check, held off while reset is low
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// clocked check that also runs through reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLKD(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: hdl/trebuf_pkg.sv
`default_nettype none

package trebuf_pkg;

    localparam int SLOTS_DEF  = 16;
    localparam int ADDR_W     = 3;
    localparam int DELAY_W    = 10;
    localparam int DELAY_US_W = 20;
    localparam int US_PER_MS  = 1000;
    localparam int DELAY_MAX  = 1000;
    localparam int DELAY_RST  = 10;
    localparam int COUNT_W    = 5;

    // register index of the hold-back delay
    localparam logic [0:0] REG_DELAY = 1'b0;

    localparam logic [2:0] MT_NOTE_OFF = 3'd0;
    localparam logic [2:0] MT_NOTE_ON  = 3'd1;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } state_t;

    typedef struct packed {
        logic [1:0] src;
        logic [7:0] d2;
        logic [7:0] d1;
        logic [3:0] chan;
        logic [2:0] mtype;
    } pay_t;

    // search word that walks down the row of slot cells
    typedef struct packed {
        logic        valid;
        op_t         op;
        logic [31:0] now;
        logic        hit;
        logic [31:0] key;
        pay_t        pay;
        logic [31:0] rx;
        logic        free_hit;
    } tok_t;

    // slot update broadcast from the controller
    typedef struct packed {
        logic        put;
        logic        clear;
        logic [31:0] rel;
        logic [31:0] rcv;
        pay_t        pay;
    } wr_t;

endpackage

`default_nettype wire

FILE: hdl/trebuf_cell.sv
`default_nettype none

module trebuf_cell
    import trebuf_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int IDX   = 0
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire tok_t                     tok_in,
    input  wire logic [$clog2(SLOTS)-1:0] hit_idx_in,
    input  wire logic [$clog2(SLOTS)-1:0] free_idx_in,
    output tok_t                          tok_out,
    output logic [$clog2(SLOTS)-1:0]      hit_idx_out,
    output logic [$clog2(SLOTS)-1:0]      free_idx_out,
    input  wire wr_t                      wr,
    input  wire logic [$clog2(SLOTS)-1:0] wr_idx
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic        valid_reg;
    logic [31:0] rel_reg;
    logic [31:0] rcv_reg;
    pay_t        pay_reg;

    tok_t             tok_reg, tok_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;

    logic take;
    logic take_free;

    // slot contents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr.put && wr_idx == MY_IDX)
        begin
            valid_reg <= 1'b1;
        end
        else if (wr.clear && wr_idx == MY_IDX)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.put && wr_idx == MY_IDX)
        begin
            rel_reg <= wr.rel;
            rcv_reg <= wr.rcv;
            pay_reg <= wr.pay;
        end
    end

    // compare against the best so far
    always_comb
    begin
        if (tok_in.op == OP_READ)
        begin
            take      = valid_reg && (rel_reg <= tok_in.now) && (rel_reg < tok_in.key);
            take_free = 1'b0;
        end
        else
        begin
            take      = !tok_in.hit || (rcv_reg < tok_in.key);
            take_free = !valid_reg && !tok_in.free_hit;
        end
    end

    always_comb
    begin
        tok_next      = tok_in;
        hit_idx_next  = hit_idx_in;
        free_idx_next = free_idx_in;
        if (take)
        begin
            tok_next.hit = 1'b1;
            tok_next.key = (tok_in.op == OP_READ) ? rel_reg : rcv_reg;
            tok_next.pay = pay_reg;
            tok_next.rx  = rcv_reg;
            hit_idx_next = MY_IDX;
        end
        if (take_free)
        begin
            tok_next.free_hit = 1'b1;
            free_idx_next     = MY_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg      <= '0;
            hit_idx_reg  <= '0;
            free_idx_reg <= '0;
        end
        else
        begin
            tok_reg      <= tok_next;
            hit_idx_reg  <= hit_idx_next;
            free_idx_reg <= free_idx_next;
        end
    end

    assign tok_out      = tok_reg;
    assign hit_idx_out  = hit_idx_reg;
    assign free_idx_out = free_idx_reg;

endmodule

`default_nettype wire

FILE: hdl/timed_release_event_buffer.sv
`default_nettype none
`include "assert_macros.svh"

// timed release event buffer: a jitter buffer for midi events held in SLOTS
// slots. pulse start for one cycle while busy is low; the command word is
// taken at that edge. operation 0 inserts the event stamped with now_us and
// due at now_us plus the hold-back delay in microseconds (note on with
// velocity zero is stored as note off); when every slot is taken the slot
// with the oldest receive time is replaced and dropped_count advances.
// operation 1 returns and frees the due event with the earliest release time,
// or found = 0 when none is due.
// each command yields exactly one result word, shown for one cycle with done
// high; the receiver cannot stall it, so it must take the word in that cycle.
// the search word walks the row of slot cells one cell per clock; when it
// leaves the last cell the chosen slot is written back and done is
// registered at that same edge. busy stays high while the word is in the row
// and drops in the cycle that done is shown, so the next start is taken at
// the edge that ends the done cycle at the earliest.
// all time compares are plain unsigned 32-bit compares. the delay register
// lies at byte address 0 and keeps the low ten bits of a write, clamped to
// 1000; write it only while busy is low, since the insert in flight uses
// the delay in force when its search word leaves the row.
module timed_release_event_buffer
    import trebuf_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    // apb-style register port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,

    // command side
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              operation,
    input  wire logic [31:0]       now_us,
    input  wire logic [2:0]        msg_type,
    input  wire logic [3:0]        channel,
    input  wire logic [7:0]        first_data,
    input  wire logic [7:0]        second_data,
    input  wire logic [1:0]        source,

    // result side
    output logic                   done,
    output logic                   found,
    output logic [2:0]             out_type,
    output logic [3:0]             out_channel,
    output logic [7:0]             out_first_data,
    output logic [7:0]             out_second_data,
    output logic [1:0]             out_source,
    output logic [31:0]            out_receive_time,
    output logic                   overwrote,
    output logic [COUNT_W-1:0]     buffered_count,
    output logic [31:0]            dropped_count,
    output logic [31:0]            received_count
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int OCC_W = $clog2(SLOTS + 1);

    // ---------------------------------------------------------------
    // register port
    // ---------------------------------------------------------------
    logic [DELAY_W-1:0]    hold_ms_reg;
    logic [DELAY_US_W-1:0] delay_us_reg;
    logic                  cfg_wr;
    logic [DELAY_W-1:0]    delay_clamped;

    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite && pready && (paddr[2] == REG_DELAY);
    assign delay_clamped = (pwdata[DELAY_W-1:0] > DELAY_W'(DELAY_MAX))
                         ? DELAY_W'(DELAY_MAX) : pwdata[DELAY_W-1:0];

    // keep the delay in microseconds too so the insert path is a plain add
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ms_reg  <= DELAY_W'(DELAY_RST);
            delay_us_reg <= DELAY_US_W'(DELAY_RST * US_PER_MS);
        end
        else if (cfg_wr)
        begin
            hold_ms_reg  <= delay_clamped;
            delay_us_reg <= DELAY_US_W'(delay_clamped * DELAY_US_W'(US_PER_MS));
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_DELAY)
        begin
            prdata = 32'(hold_ms_reg);
        end
    end

    // ---------------------------------------------------------------
    // command capture and sequencing
    // ---------------------------------------------------------------
    state_t state_reg, state_next;
    logic   accept;
    pay_t   item_pay_reg;
    pay_t   in_pay;

    tok_t             tok_chain  [0:SLOTS];
    logic [IDX_W-1:0] hidx_chain [0:SLOTS];
    logic [IDX_W-1:0] fidx_chain [0:SLOTS];
    tok_t             tok_head;
    tok_t             tok_last;

    assign accept   = start && !busy;
    assign tok_last = tok_chain[SLOTS];

    // note on with zero velocity is a note off
    always_comb
    begin
        in_pay.src   = source;
        in_pay.d2    = second_data;
        in_pay.d1    = first_data;
        in_pay.chan  = channel;
        in_pay.mtype = msg_type;
        if (msg_type == MT_NOTE_ON && second_data == 8'd0)
        begin
            in_pay.mtype = MT_NOTE_OFF;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_pay_reg <= in_pay;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (tok_last.valid)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE:  busy = 1'b0;
            ST_SCAN:  busy = 1'b1;
            default:  busy = 1'b1;
        endcase
    end

    // ---------------------------------------------------------------
    // row of slot cells; the search word enters cell 0 at the accept edge
    // ---------------------------------------------------------------
    always_comb
    begin
        tok_head          = '0;
        tok_head.valid    = accept;
        tok_head.op       = op_t'(operation);
        tok_head.now      = now_us;
        tok_head.hit      = 1'b0;
        tok_head.key      = '1;
        tok_head.free_hit = 1'b0;
    end

    assign tok_chain[0]  = tok_head;
    assign hidx_chain[0] = '0;
    assign fidx_chain[0] = '0;

    wr_t              wr;
    logic [IDX_W-1:0] wr_idx;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            trebuf_cell #(
                .SLOTS (SLOTS),
                .IDX   (g)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .tok_in       (tok_chain[g]),
                .hit_idx_in   (hidx_chain[g]),
                .free_idx_in  (fidx_chain[g]),
                .tok_out      (tok_chain[g+1]),
                .hit_idx_out  (hidx_chain[g+1]),
                .free_idx_out (fidx_chain[g+1]),
                .wr           (wr),
                .wr_idx       (wr_idx)
            );
        end
    endgenerate

    // ---------------------------------------------------------------
    // write-back when the search word leaves the last cell
    // ---------------------------------------------------------------
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic [31:0]      dropped_reg, dropped_next;
    logic [31:0]      received_reg, received_next;
    logic             commit;

    assign commit = tok_last.valid;

    always_comb
    begin
        wr            = '0;
        wr.rcv        = tok_last.now;
        wr.rel        = tok_last.now + 32'(delay_us_reg);
        wr.pay        = item_pay_reg;
        wr_idx        = hidx_chain[SLOTS];
        occ_next      = occ_reg;
        dropped_next  = dropped_reg;
        received_next = received_reg;
        if (commit)
        begin
            if (tok_last.op == OP_INSERT)
            begin
                wr.put        = 1'b1;
                received_next = received_reg + 32'd1;
                if (tok_last.free_hit)
                begin
                    // lowest free slot
                    wr_idx   = fidx_chain[SLOTS];
                    occ_next = occ_reg + OCC_W'(1);
                end
                else
                begin
                    // full: replace the oldest
                    dropped_next = dropped_reg + 32'd1;
                end
            end
            else if (tok_last.hit)
            begin
                wr.clear = 1'b1;
                if (occ_reg != '0)
                begin
                    occ_next = occ_reg - OCC_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg      <= '0;
            dropped_reg  <= '0;
            received_reg <= '0;
            done         <= 1'b0;
        end
        else
        begin
            occ_reg      <= occ_next;
            dropped_reg  <= dropped_next;
            received_reg <= received_next;
            done         <= commit;
        end
    end

    // result word; event fields read zero unless an event is returned
    logic read_hit;
    assign read_hit = (tok_last.op == OP_READ) && tok_last.hit;

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            found            <= read_hit;
            out_type         <= read_hit ? tok_last.pay.mtype : 3'd0;
            out_channel      <= read_hit ? tok_last.pay.chan  : 4'd0;
            out_first_data   <= read_hit ? tok_last.pay.d1    : 8'd0;
            out_second_data  <= read_hit ? tok_last.pay.d2    : 8'd0;
            out_source       <= read_hit ? tok_last.pay.src   : 2'd0;
            out_receive_time <= read_hit ? tok_last.rx        : 32'd0;
            overwrote        <= (tok_last.op == OP_INSERT) && !tok_last.free_hit;
        end
    end

    assign buffered_count = COUNT_W'(occ_reg);
    assign dropped_count  = dropped_reg;
    assign received_count = received_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `ASSERT_CLKD(a_done_after_scan, clk, rst_n, done |-> $past(state_reg == ST_SCAN),
                 "result word without a command in flight")
    `ASSERT_CLKD(a_occ_bound, clk, rst_n, occ_reg <= OCC_W'(SLOTS),
                 "slot count above capacity")
    `ASSERT_CLKD(a_found_not_insert, clk, rst_n, done && found |-> !overwrote,
                 "read result flagged as overwrite")
    `ASSERT_CLKD(a_word_in_scan, clk, rst_n, tok_last.valid |-> state_reg == ST_SCAN,
                 "search word left the row while idle")
    `ASSERT_CLKD(a_insert_counts, clk, rst_n,
                 commit && tok_last.op == OP_INSERT
                     |=> received_reg == $past(received_reg) + 32'd1,
                 "insert did not advance the received count")

endmodule

`default_nettype wire

FILE: tb/tb_timed_release_event_buffer.sv
`timescale 1ns / 1ps

module tb_timed_release_event_buffer;
    import trebuf_pkg::*;

    localparam int NSLOT          = SLOTS_DEF;
    // used to size the final wait after the queue drains
    localparam int RESULT_LATENCY = NSLOT + 1;
    // run-away limit, with a wide margin over the slowest correct run
    localparam int CYCLE_LIMIT    = 400000;
    localparam logic [ADDR_W-1:0] DELAY_ADDR = ADDR_W'(4 * int'(REG_DELAY));

    // one command word as the sender sees it
    typedef struct packed {
        op_t         op;
        logic [31:0] now;
        logic [2:0]  mtype;
        logic [3:0]  chan;
        logic [7:0]  d1;
        logic [7:0]  d2;
        logic [1:0]  src;
    } midi_cmd_t;

    // one result word, in port order
    typedef struct packed {
        logic               found;
        logic [2:0]         mtype;
        logic [3:0]         chan;
        logic [7:0]         d1;
        logic [7:0]         d2;
        logic [1:0]         src;
        logic [31:0]        rx;
        logic               overwrote;
        logic [COUNT_W-1:0] count;
        logic [31:0]        drops;
        logic [31:0]        inserts;
    } release_word_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               start;
    logic               busy;
    logic               operation;
    logic [31:0]        now_us;
    logic [2:0]         msg_type;
    logic [3:0]         channel;
    logic [7:0]         first_data;
    logic [7:0]         second_data;
    logic [1:0]         source;
    logic               done;
    logic               found;
    logic [2:0]         out_type;
    logic [3:0]         out_channel;
    logic [7:0]         out_first_data;
    logic [7:0]         out_second_data;
    logic [1:0]         out_source;
    logic [31:0]        out_receive_time;
    logic               overwrote;
    logic [COUNT_W-1:0] buffered_count;
    logic [31:0]        dropped_count;
    logic [31:0]        received_count;

    timed_release_event_buffer #(
        .SLOTS(NSLOT)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .start            (start),
        .busy             (busy),
        .operation        (operation),
        .now_us           (now_us),
        .msg_type         (msg_type),
        .channel          (channel),
        .first_data       (first_data),
        .second_data      (second_data),
        .source           (source),
        .done             (done),
        .found            (found),
        .out_type         (out_type),
        .out_channel      (out_channel),
        .out_first_data   (out_first_data),
        .out_second_data  (out_second_data),
        .out_source       (out_source),
        .out_receive_time (out_receive_time),
        .overwrote        (overwrote),
        .buffered_count   (buffered_count),
        .dropped_count    (dropped_count),
        .received_count   (received_count)
    );

    // shadow copy of the slot store and counters
    logic               slot_live  [NSLOT];
    logic [31:0]        slot_due   [NSLOT];
    logic [31:0]        slot_stamp [NSLOT];
    pay_t               slot_event [NSLOT];
    logic [COUNT_W-1:0] live_count;
    logic [31:0]        drop_total;
    logic [31:0]        insert_total;
    logic [9:0]         hold_ms;

    // result words predicted at accept time, oldest first
    release_word_t      predicted_words[$];
    int                 mismatches;
    bit                 sender_idles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run-away guard
    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[timed_release_event_buffer] ERROR");
        $finish;
    end

    task automatic clear_buffer_model();
        for (int i = 0; i < NSLOT; i++)
        begin
            slot_live[i]  = 1'b0;
            slot_due[i]   = '0;
            slot_stamp[i] = '0;
            slot_event[i] = '0;
        end
        live_count   = '0;
        drop_total   = '0;
        insert_total = '0;
        hold_ms      = 10'(DELAY_RST);
    endtask

    // applies one command to the shadow store and returns the word it yields
    task automatic buffer_step(input midi_cmd_t c, output release_word_t w);
        pay_t        ev;
        int          pick;
        logic [31:0] pick_time;
        w = '0;
        if (c.op == OP_INSERT)
        begin
            insert_total++;
            // note on with zero velocity is kept as note off
            ev.mtype = (c.mtype == MT_NOTE_ON && c.d2 == 8'd0) ? MT_NOTE_OFF : c.mtype;
            ev.chan  = c.chan;
            ev.d1    = c.d1;
            ev.d2    = c.d2;
            ev.src   = c.src;
            pick = -1;
            for (int i = 0; i < NSLOT; i++)
                if (!slot_live[i] && pick < 0)
                    pick = i;
            if (pick < 0)
            begin
                // full: oldest receive time goes, strict compare keeps the lowest index
                pick = 0;
                for (int i = 1; i < NSLOT; i++)
                    if (slot_stamp[i] < slot_stamp[pick])
                        pick = i;
                drop_total++;
                w.overwrote = 1'b1;
            end
            else
                live_count++;
            slot_event[pick] = ev;
            slot_stamp[pick] = c.now;
            slot_due[pick]   = c.now + 32'(hold_ms) * 32'd1000;
            slot_live[pick]  = 1'b1;
        end
        else
        begin
            // due and strictly below all ones, earliest release, lowest index on ties
            pick      = -1;
            pick_time = '1;
            for (int i = 0; i < NSLOT; i++)
                if (slot_live[i] && slot_due[i] <= c.now && slot_due[i] < pick_time)
                begin
                    pick      = i;
                    pick_time = slot_due[i];
                end
            if (pick >= 0)
            begin
                w.found = 1'b1;
                w.mtype = slot_event[pick].mtype;
                w.chan  = slot_event[pick].chan;
                w.d1    = slot_event[pick].d1;
                w.d2    = slot_event[pick].d2;
                w.src   = slot_event[pick].src;
                w.rx    = slot_stamp[pick];
                slot_live[pick] = 1'b0;
                if (live_count != '0)
                    live_count--;
            end
        end
        w.count   = live_count;
        w.drops   = drop_total;
        w.inserts = insert_total;
    endtask

    function automatic string fmt_word(input release_word_t w);
        return $sformatf("found=%0d type=%0d ch=%0d d1=%0h d2=%0h src=%0d rx=%h ow=%0d n=%0d drop=%0d rcv=%0d",
                         w.found, w.mtype, w.chan, w.d1, w.d2, w.src, w.rx,
                         w.overwrote, w.count, w.drops, w.inserts);
    endfunction

    task automatic note_mismatch(input string what, input release_word_t want,
                                 input release_word_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch (%s) at %0t", what, $realtime);
            $display("  expected %s", fmt_word(want));
            $display("  actual   %s", fmt_word(got));
        end
    endtask

    // result words are taken at the edge that ends the done cycle
    always @(posedge clk)
    begin : check_words
        release_word_t got;
        release_word_t want;
        if (rst_n && done)
        begin
            got = '{found: found, mtype: out_type, chan: out_channel,
                    d1: out_first_data, d2: out_second_data, src: out_source,
                    rx: out_receive_time, overwrote: overwrote,
                    count: buffered_count, drops: dropped_count,
                    inserts: received_count};
            if (predicted_words.size() == 0)
                note_mismatch("no word expected", '0, got);
            else
            begin
                want = predicted_words.pop_front();
                if (got !== want)
                    note_mismatch("field", want, got);
            end
        end
    end

    function automatic midi_cmd_t make_cmd(input op_t op, input logic [31:0] now,
                                           input logic [2:0] mt, input logic [3:0] ch,
                                           input logic [7:0] d1, input logic [7:0] d2,
                                           input logic [1:0] src);
        midi_cmd_t c;
        c.op    = op;
        c.now   = now;
        c.mtype = mt;
        c.chan  = ch;
        c.d1    = d1;
        c.d2    = d2;
        c.src   = src;
        return c;
    endfunction

    // random event contents, leaning toward note on and zero velocity
    function automatic midi_cmd_t rand_cmd(input op_t op, input logic [31:0] now);
        midi_cmd_t c;
        c.op    = op;
        c.now   = now;
        c.mtype = ($urandom_range(3) == 0) ? MT_NOTE_ON : 3'($urandom_range(7));
        c.chan  = 4'($urandom_range(15));
        c.d1    = 8'($urandom_range(255));
        c.d2    = ($urandom_range(5) == 0) ? 8'd0 : 8'($urandom_range(255));
        c.src   = 2'($urandom_range(3));
        return c;
    endfunction

    // time stamp for noise words, with the ends of the range thrown in
    function automatic logic [31:0] rand_time();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'hFFFF_FFFE;
            default: return $urandom;
        endcase
    endfunction

    // offers one command word until it is taken; when sender_idles is set, start
    // may idle at random on any cycle, busy or not; returns at the next falling edge
    task automatic send_cmd(input midi_cmd_t c);
        release_word_t w;
        logic          hold;
        forever
        begin
            hold = sender_idles && ($urandom_range(99) < 20);
            start       <= !hold;
            operation   <= c.op;
            now_us      <= c.now;
            msg_type    <= c.mtype;
            channel     <= c.chan;
            first_data  <= c.d1;
            second_data <= c.d2;
            source      <= c.src;
            @(posedge clk);
            if (!hold && !busy)
                break;
            @(negedge clk);
        end
        buffer_step(c, w);
        predicted_words.push_back(w);
        @(negedge clk);
    endtask

    task automatic insert_event(input logic [31:0] now, input logic [2:0] mt,
                                input logic [3:0] ch, input logic [7:0] d1,
                                input logic [7:0] d2, input logic [1:0] src);
        send_cmd(make_cmd(OP_INSERT, now, mt, ch, d1, d2, src));
    endtask

    task automatic read_event(input logic [31:0] now);
        send_cmd(rand_cmd(OP_READ, now));
    endtask

    // stop offering words and wait for every predicted word to come back
    task automatic wait_drained();
        start <= 1'b0;
        while (predicted_words.size() != 0)
            @(negedge clk);
    endtask

    // apb write of the delay register: setup cycle, then access cycle
    task automatic write_delay(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DELAY_ADDR;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        // only the low ten bits land, then the clamp applies
        hold_ms = (value[9:0] > 10'(DELAY_MAX)) ? 10'(DELAY_MAX) : value[9:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // reset value of the delay: not due one microsecond early, due on time
    task automatic test_reset_delay();
        insert_event(32'd1000, 3'd2, 4'd5, 8'd60, 8'd100, 2'd0);
        read_event(32'd10999);
        read_event(32'd11000);
        wait_drained();
    endtask

    // all-ones and all-zero contents, time stamps at zero and one below all ones
    task automatic test_field_extremes();
        write_delay(32'd0);
        insert_event(32'hFFFF_FFFE, 3'd7, 4'd15, 8'hFF, 8'hFF, 2'd3);
        insert_event(32'd0, 3'd0, 4'd0, 8'h00, 8'h00, 2'd0);
        read_event(32'd0);
        read_event(32'hFFFF_FFFE);
        wait_drained();
    endtask

    // velocity zero note on turns into note off; equal release goes to lowest slot
    task automatic test_note_on_zero_velocity();
        insert_event(32'd500, MT_NOTE_ON, 4'd3, 8'd64, 8'd0, 2'd1);
        insert_event(32'd500, MT_NOTE_ON, 4'd3, 8'd64, 8'd1, 2'd2);
        read_event(32'd500);
        read_event(32'd500);
        wait_drained();
    endtask

    // a release time of all ones is never due, even at the last microsecond
    task automatic test_release_all_ones();
        write_delay(32'd1);
        insert_event(32'hFFFF_FC17, 3'd4, 4'd9, 8'd17, 8'd33, 2'd2);
        read_event(32'hFFFF_FFFF);
        wait_drained();
    endtask

    // fill every slot, then overwrite: first the strictly oldest (the never
    // due word from before), then a tie that must go to the lowest index
    task automatic test_full_overwrite();
        write_delay(32'd0);
        for (int i = 1; i < NSLOT; i++)
            send_cmd(rand_cmd(OP_INSERT, 32'hFFFF_FFFE));
        send_cmd(rand_cmd(OP_INSERT, 32'hFFFF_FFFE));
        send_cmd(rand_cmd(OP_INSERT, 32'hFFFF_FFFE));
        wait_drained();
    endtask

    // one setting of the delay: mostly a running clock with inserts and reads,
    // some noise words at any time stamp
    task automatic run_phase(input int items, input logic [31:0] delay_word,
                             input logic [31:0] t0, input bit idles, input bit pause);
        logic [31:0] clock_us;
        logic [31:0] span;
        int          ins_pct;
        wait_drained();
        write_delay(delay_word);
        sender_idles = idles;
        clock_us     = t0;
        // an event comes due after a handful of steps on average
        span         = (32'(hold_ms) * 32'd1000) / 4 + 32'd20;
        ins_pct      = $urandom_range(70, 35);
        for (int n = 0; n < items; n++)
        begin
            if (pause && n == items / 2)
                wait_drained();
            if ($urandom_range(99) < 15)
                send_cmd(rand_cmd(op_t'($urandom_range(1)), rand_time()));
            else
            begin
                clock_us = clock_us + $urandom_range(span);
                if ($urandom_range(99) < ins_pct)
                    send_cmd(rand_cmd(OP_INSERT, clock_us));
                else
                    send_cmd(rand_cmd(OP_READ, clock_us));
            end
        end
    endtask

    task automatic test_random_phases();
        run_phase(175, 32'd1001, 32'hFFFF_FF00, 1'b1, 1'b0);       // clamps to 1000
        run_phase(175, 32'd0, $urandom, 1'b0, 1'b0);               // no idling
        run_phase(175, 32'hFFFF_FC02, 32'hFFFF_F000, 1'b1, 1'b1);  // low bits give 2, wraps
        run_phase(175, 32'hFFFF_FFFF, $urandom, 1'b1, 1'b0);       // 1023 clamps to 1000
        run_phase(175, 32'd1000, 32'd0, 1'b1, 1'b0);
        run_phase(175, 32'($urandom_range(20, 1)), $urandom, 1'b1, 1'b0);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        start        = 1'b0;
        operation    = 1'b0;
        now_us       = '0;
        msg_type     = '0;
        channel      = '0;
        first_data   = '0;
        second_data  = '0;
        source       = '0;
        mismatches   = 0;
        sender_idles = 1'b1;
        clear_buffer_model();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_delay();
        test_field_extremes();
        test_note_on_zero_velocity();
        test_release_all_ones();
        test_full_overwrite();
        test_random_phases();

        wait_drained();
        repeat (RESULT_LATENCY + 4) @(negedge clk);
        if (predicted_words.size() != 0)
            $display("words still expected: %0d", predicted_words.size());
        if (mismatches == 0 && predicted_words.size() == 0)
            $display("[timed_release_event_buffer] OK");
        else
            $display("[timed_release_event_buffer] ERROR");
        $finish;
    end

endmodule
